// ===== src/bbx_pkg.sv =====
// Shared types, constants and the reciprocal table of the box blur scrambler.
// Used by bbx_ctrl, bbx_datapath and box_blur_xor_scrambler; depends on nothing.
package bbx_pkg;

   // Parameter defaults
   localparam int MAX_SIDE_DEF     = 16;
   localparam int CHUNK_PIXELS_DEF = 32;

   // Register indexes and field widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int SIDE_REG_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SCRAMBLE_KEY = 2'd2;
   localparam logic [SIDE_REG_W-1:0]  SIDE_RESET       = 5'd16;

   // Keystream step per pixel index
   localparam logic [7:0] KEY_STEP = 8'd13;

   // Window arithmetic: sum of up to nine bytes, count 1..9
   localparam int SUM_W    = 12;
   localparam int CNT_W    = 4;
   localparam int RECIP_W  = 17;
   localparam int RECIP_SH = 16;
   localparam logic [CNT_W-1:0] CNT_MAX = 4'd9;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELECT,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } bbx_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // take the input beat and write it to the store
      logic start;   // pick the next pending output pixel, set up its window
      logic read;    // read one window entry
      logic finish;  // divide, scramble and load the output register
   } bbx_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic has_emit;  // an output pixel is still pending for this input
      logic win_end;   // the window cursor sits on its last entry
      logic out_free;  // the output register can take a new beat
   } bbx_sts_type;

   // ceil(2^16 / n): floor(sum * recip >> 16) equals sum / n for sum < 2^13
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/bbx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the pixel store of the box blur scrambler; no dependencies.
module bbx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bbx_ctrl.sv =====
// Controller state machine of the box blur scrambler.
// Depends on bbx_pkg; drives bbx_datapath through command and status structs.
module bbx_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bbx_pkg::bbx_sts_type sts,
   output bbx_pkg::bbx_cmd_type cmd
);

   bbx_pkg::bbx_state_type state_ff;
   bbx_pkg::bbx_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbx_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         bbx_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = bbx_pkg::ST_SELECT;
            end
         end
         bbx_pkg::ST_SELECT: begin
            if (sts.has_emit) begin
               cmd.start = 1'b1;
               state_in  = bbx_pkg::ST_READ;
            end else begin
               state_in = bbx_pkg::ST_IDLE;
            end
         end
         bbx_pkg::ST_READ: begin
            cmd.read = 1'b1;
            if (sts.win_end) begin
               state_in = bbx_pkg::ST_DRAIN;
            end
         end
         bbx_pkg::ST_DRAIN: begin
            // last read data lands in the sum this cycle
            state_in = bbx_pkg::ST_FINISH;
         end
         bbx_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = bbx_pkg::ST_SELECT;
            end
         end
         default: begin
            state_in = bbx_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/bbx_datapath.sv =====
// Datapath of the box blur scrambler: geometry, pixel store, window sum,
// reciprocal divide, keystream and output register. Depends on bbx_pkg, bbx_ram.
module bbx_datapath #(
   parameter int MAX_SIDE     = bbx_pkg::MAX_SIDE_DEF,
   parameter int CHUNK_PIXELS = bbx_pkg::CHUNK_PIXELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bbx_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bbx_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [7:0]                          req_pixel_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_cipher_byte,
   output logic [7:0]                          rsp_pixel_index,
   output logic [3:0]                          rsp_chunk_number,
   output logic                                rsp_chunk_last,
   output logic                                rsp_image_last,
   output logic                                rsp_run_last,
   input  bbx_pkg::bbx_cmd_type                cmd,
   output bbx_pkg::bbx_sts_type                sts
);

   localparam int CW = $clog2(MAX_SIDE);
   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int XW = (AW > 8) ? AW : 8;
   localparam int PW = $clog2(CHUNK_PIXELS + 1);
   localparam int PROD_W = bbx_pkg::SUM_W + bbx_pkg::RECIP_W;

   // Configuration registers
   logic [bbx_pkg::SIDE_REG_W-1:0] width_ff, width_in;
   logic [bbx_pkg::SIDE_REG_W-1:0] height_ff, height_in;
   logic [7:0]                     key_ff, key_in;

   // Input position and pending output pixels
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CW-1:0] cur_c_ff, cur_c_in, cur_r_ff, cur_r_in;
   logic          pend_lo_ff, pend_lo_in, pend_hi_ff, pend_hi_in;
   logic          pend_last_ff, pend_last_in;
   logic [CW-1:0] last_x_ff, last_x_in;

   // Window cursor and sum
   logic [CW-1:0] x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [CW-1:0] wx_ff, wx_in, wy_ff, wy_in;
   logic [bbx_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [bbx_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic          rd_valid_ff;
   logic          run_last_ff, run_last_in;
   logic          img_end_ff, img_end_in;

   // Output counters and output register
   logic [XW-1:0] idx_ff, idx_in;
   logic [PW-1:0] cpos_ff, cpos_in;
   logic [3:0]    cnum_ff, cnum_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_cipher_ff, rsp_cipher_in;
   logic [7:0]    rsp_index_ff, rsp_index_in;
   logic [3:0]    rsp_cnum_ff, rsp_cnum_in;
   logic          rsp_clast_ff, rsp_clast_in;
   logic          rsp_ilast_ff, rsp_ilast_in;
   logic          rsp_rlast_ff, rsp_rlast_in;

   // Combinational helpers
   logic [SW-1:0] side_w, side_h;
   logic [CW-1:0] w_m1, h_m1;
   logic [CW-1:0] pos_c, pos_r;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    rd_data;
   logic [CW-1:0] sel_x, sel_y;
   logic          more_after;
   logic [PROD_W-1:0] prod;
   logic [7:0]    ks;
   logic          geom_write;

   // Clamp geometry to 1..MAX_SIDE
   always_comb begin
      if (width_ff == '0) begin
         side_w = SW'(1);
      end else if (32'(width_ff) > MAX_SIDE) begin
         side_w = SW'(MAX_SIDE);
      end else begin
         side_w = SW'(width_ff);
      end
      if (height_ff == '0) begin
         side_h = SW'(1);
      end else if (32'(height_ff) > MAX_SIDE) begin
         side_h = SW'(MAX_SIDE);
      end else begin
         side_h = SW'(height_ff);
      end
      w_m1 = CW'(side_w - SW'(1));
      h_m1 = CW'(side_h - SW'(1));
   end

   // Position of the incoming pixel, restarted if it falls outside the image
   always_comb begin
      if (SW'(col_ff) >= side_w || SW'(row_ff) >= side_h) begin
         pos_c = '0;
         pos_r = '0;
      end else begin
         pos_c = col_ff;
         pos_r = row_ff;
      end
      wr_addr = AW'(pos_r) * AW'(side_w) + AW'(pos_c);
      rd_addr = AW'(wy_ff) * AW'(side_w) + AW'(wx_ff);
   end

   // Pick the next output pixel: left neighbor above, right edge above, last row
   always_comb begin
      if (pend_lo_ff) begin
         sel_x      = cur_c_ff - CW'(1);
         sel_y      = cur_r_ff - CW'(1);
         more_after = pend_hi_ff | pend_last_ff;
      end else if (pend_hi_ff) begin
         sel_x      = cur_c_ff;
         sel_y      = cur_r_ff - CW'(1);
         more_after = pend_last_ff;
      end else begin
         sel_x      = last_x_ff;
         sel_y      = cur_r_ff;
         more_after = (last_x_ff != w_m1);
      end
   end

   // Divide by the window count and build the keystream byte
   assign prod = PROD_W'(sum_ff) * PROD_W'(bbx_pkg::recip(cnt_ff));
   assign ks   = 8'(key_ff + idx_ff[7:0] * bbx_pkg::KEY_STEP);

   assign geom_write = csr_wr_en && (csr_index == bbx_pkg::REG_IMAGE_WIDTH ||
                                     csr_index == bbx_pkg::REG_IMAGE_HEIGHT);

   // Next-state logic
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      key_in       = key_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cur_c_in     = cur_c_ff;
      cur_r_in     = cur_r_ff;
      pend_lo_in   = pend_lo_ff;
      pend_hi_in   = pend_hi_ff;
      pend_last_in = pend_last_ff;
      last_x_in    = last_x_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      run_last_in  = run_last_ff;
      img_end_in   = img_end_ff;
      idx_in       = idx_ff;
      cpos_in      = cpos_ff;
      cnum_in      = cnum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cipher_in = rsp_cipher_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_cnum_in   = rsp_cnum_ff;
      rsp_clast_in  = rsp_clast_ff;
      rsp_ilast_in  = rsp_ilast_ff;
      rsp_rlast_in  = rsp_rlast_ff;

      // Take the input beat: note which output pixels it completes, advance
      if (cmd.load) begin
         cur_c_in     = pos_c;
         cur_r_in     = pos_r;
         pend_lo_in   = (pos_r != '0) && (pos_c != '0);
         pend_hi_in   = (pos_r != '0) && (pos_c == w_m1);
         pend_last_in = (pos_r == h_m1) && (pos_c == w_m1);
         last_x_in    = '0;
         if (pos_c == w_m1) begin
            col_in = '0;
            row_in = (pos_r == h_m1) ? '0 : pos_r + CW'(1);
         end else begin
            col_in = pos_c + CW'(1);
            row_in = pos_r;
         end
      end

      // Consume one pending pixel and set up its clipped window
      if (cmd.start) begin
         if (pend_lo_ff) begin
            pend_lo_in = 1'b0;
         end else if (pend_hi_ff) begin
            pend_hi_in = 1'b0;
         end else begin
            last_x_in    = last_x_ff + CW'(1);
            pend_last_in = (last_x_ff != w_m1);
         end
         x0_in = (sel_x == '0) ? '0 : sel_x - CW'(1);
         x1_in = (SW'(sel_x) + SW'(1) < side_w) ? sel_x + CW'(1) : w_m1;
         y1_in = (SW'(sel_y) + SW'(1) < side_h) ? sel_y + CW'(1) : h_m1;
         wx_in = (sel_x == '0) ? '0 : sel_x - CW'(1);
         wy_in = (sel_y == '0) ? '0 : sel_y - CW'(1);
         sum_in      = '0;
         cnt_in      = '0;
         run_last_in = !more_after;
         img_end_in  = (sel_x == w_m1) && (sel_y == h_m1);
      end else if (rd_valid_ff) begin
         sum_in = sum_ff + bbx_pkg::SUM_W'(rd_data);
         cnt_in = cnt_ff + bbx_pkg::CNT_W'(1);
      end

      // Walk the window in raster order
      if (cmd.read) begin
         if (wx_ff == x1_ff) begin
            wx_in = x0_ff;
            wy_in = wy_ff + CW'(1);
         end else begin
            wx_in = wx_ff + CW'(1);
         end
      end

      // Drop the output beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Load the output register and advance the raster counters
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_cipher_in = prod[bbx_pkg::RECIP_SH +: 8] ^ ks;
         rsp_index_in  = idx_ff[7:0];
         rsp_cnum_in   = cnum_ff;
         rsp_clast_in  = (cpos_ff == PW'(CHUNK_PIXELS - 1)) || img_end_ff;
         rsp_ilast_in  = img_end_ff;
         rsp_rlast_in  = run_last_ff;
         if (img_end_ff) begin
            idx_in  = '0;
            cpos_in = '0;
            cnum_in = 4'd1;
         end else begin
            idx_in = idx_ff + XW'(1);
            if (cpos_ff == PW'(CHUNK_PIXELS - 1)) begin
               cpos_in = '0;
               cnum_in = cnum_ff + 4'd1;
            end else begin
               cpos_in = cpos_ff + PW'(1);
            end
         end
      end

      // Configuration writes; a geometry change restarts the image
      if (csr_wr_en) begin
         case (csr_index)
            bbx_pkg::REG_IMAGE_WIDTH:  width_in  = csr_wdata[bbx_pkg::SIDE_REG_W-1:0];
            bbx_pkg::REG_IMAGE_HEIGHT: height_in = csr_wdata[bbx_pkg::SIDE_REG_W-1:0];
            bbx_pkg::REG_SCRAMBLE_KEY: key_in    = csr_wdata;
            default: ;
         endcase
      end
      if (geom_write) begin
         col_in  = '0;
         row_in  = '0;
         idx_in  = '0;
         cpos_in = '0;
         cnum_in = 4'd1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bbx_pkg::SIDE_RESET;
         height_ff    <= bbx_pkg::SIDE_RESET;
         key_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_lo_ff   <= 1'b0;
         pend_hi_ff   <= 1'b0;
         pend_last_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         idx_ff       <= '0;
         cpos_ff      <= '0;
         cnum_ff      <= 4'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         key_ff       <= key_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_lo_ff   <= pend_lo_in;
         pend_hi_ff   <= pend_hi_in;
         pend_last_ff <= pend_last_in;
         rd_valid_ff  <= cmd.read;
         idx_ff       <= idx_in;
         cpos_ff      <= cpos_in;
         cnum_ff      <= cnum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_c_ff      <= cur_c_in;
      cur_r_ff      <= cur_r_in;
      last_x_ff     <= last_x_in;
      x0_ff         <= x0_in;
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      wx_ff         <= wx_in;
      wy_ff         <= wy_in;
      sum_ff        <= sum_in;
      cnt_ff        <= cnt_in;
      run_last_ff   <= run_last_in;
      img_end_ff    <= img_end_in;
      rsp_cipher_ff <= rsp_cipher_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_cnum_ff   <= rsp_cnum_in;
      rsp_clast_ff  <= rsp_clast_in;
      rsp_ilast_ff  <= rsp_ilast_in;
      rsp_rlast_ff  <= rsp_rlast_in;
   end

   // Pixel store
   bbx_ram #(
      .WIDTH (8),
      .DEPTH (MAX_SIDE * MAX_SIDE)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_value),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status and outputs
   assign sts.has_emit = pend_lo_ff | pend_hi_ff | pend_last_ff;
   assign sts.win_end  = (wx_ff == x1_ff) && (wy_ff == y1_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cipher_byte  = rsp_cipher_ff;
   assign rsp_pixel_index  = rsp_index_ff;
   assign rsp_chunk_number = rsp_cnum_ff;
   assign rsp_chunk_last   = rsp_clast_ff;
   assign rsp_image_last   = rsp_ilast_ff;
   assign rsp_run_last     = rsp_rlast_ff;

   // Checks
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("output beat not presented after load");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (cnt_ff != '0 && cnt_ff <= bbx_pkg::CNT_MAX))
      else $error("window count out of range at divide");

   a_no_wr_during_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!cmd.read && !rd_valid_ff))
      else $error("store write overlaps a window read");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (!rd_valid_ff && sts.has_emit))
      else $error("window started with reads in flight or nothing pending");

endmodule

// ===== src/box_blur_xor_scrambler.sv =====
// Top level of the 3x3 box blur with XOR keystream.
// Depends on bbx_pkg; instantiates bbx_ctrl and bbx_datapath.
//
// Usage:
//   req_* takes one 8-bit pixel per beat in raster order. rsp_* gives the
//   blurred, scrambled pixels in raster order with index, chunk number and
//   end marks; rsp_run_last marks the last beat caused by one input beat.
//   csr_* writes image_width (0), image_height (1) and scramble_key (2)
//   while the block is idle; a geometry write restarts the image.
// Timing:
//   A pixel that completes no window passes through accept and select only.
//   Each output pixel then passes through select, window reads, drain and
//   divide-and-scramble. The N = 1 to 9 window entries (4, 6 or 9 unless a side
//   is 1) come through the single read port of the store, one entry per cycle.
//   A result is presented once divide-and-scramble loads the output register.
// Reset:
//   Synchronous; geometry returns to 16 x 16, key to 0, position to (0,0).
//   Store contents are not cleared; only pixels of the current image are read.
// Stall:
//   One output register holds a beat while rsp_ready is low; the next pixel
//   is computed meanwhile and waits in the divide stage until the register frees.
module box_blur_xor_scrambler #(
   parameter int MAX_SIDE     = bbx_pkg::MAX_SIDE_DEF,
   parameter int CHUNK_PIXELS = bbx_pkg::CHUNK_PIXELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [bbx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bbx_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_pixel_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_cipher_byte,
   output logic [7:0]                      rsp_pixel_index,
   output logic [3:0]                      rsp_chunk_number,
   output logic                            rsp_chunk_last,
   output logic                            rsp_image_last,
   output logic                            rsp_run_last
);

   bbx_pkg::bbx_cmd_type cmd;
   bbx_pkg::bbx_sts_type sts;

   // Sequencer
   bbx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store, window arithmetic and output register
   bbx_datapath #(
      .MAX_SIDE     (MAX_SIDE),
      .CHUNK_PIXELS (CHUNK_PIXELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cipher_byte  (rsp_cipher_byte),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_chunk_number (rsp_chunk_number),
      .rsp_chunk_last   (rsp_chunk_last),
      .rsp_image_last   (rsp_image_last),
      .rsp_run_last     (rsp_run_last),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
